>>> rtl/hlf_pkg.sv
// Shared types, constants and a helper function for the hex line frame parser.
package hlf_pkg;

  localparam int LINE_LIMIT  = 50;
  localparam int KEPT_CHARS  = 24;
  localparam int FRAME_BYTES = KEPT_CHARS / 2;
  localparam int CNT_W       = $clog2(LINE_LIMIT);
  localparam int IDX_W       = $clog2(KEPT_CHARS);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;

  typedef logic [7:0] char_t;
  typedef logic [KEPT_CHARS-1:0][7:0] line_t;

  // One completed line handed from the front to the back.
  typedef struct packed {
    line_t chars;
    logic  full;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic        push_message;
    logic        dropped_full;
    logic        checksum_bad;
    logic        reply_ok;
    logic [10:0] can_id;
    logic [55:0] can_payload;
    logic [63:0] frame_head;
    logic [31:0] frame_tail;
  } result_t;

  // Non-hex characters decode as zero.
  function automatic logic [3:0] hex_nibble(input char_t c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - CH_ZERO;
    end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
      d = c - CH_UP_A + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

>>> rtl/hlf_if.sv
// Channel interfaces for the character input and the decoded frame output.
interface hlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       queue_full;

  modport source (output valid, ch, queue_full, input ready);
  modport sink   (input valid, ch, queue_full, output ready);
endinterface

interface hlf_out_if;
  logic        valid;
  logic        ready;
  logic        push_message;
  logic        dropped_full;
  logic        checksum_bad;
  logic        reply_ok;
  logic [10:0] can_id;
  logic [55:0] can_payload;
  logic [63:0] frame_head;
  logic [31:0] frame_tail;

  modport source (output valid, push_message, dropped_full, checksum_bad, reply_ok,
                  can_id, can_payload, frame_head, frame_tail, input ready);
  modport sink   (input valid, push_message, dropped_full, checksum_bad, reply_ok,
                  can_id, can_payload, frame_head, frame_tail, output ready);
endinterface

>>> rtl/hlf_front.sv
// Front end: collects characters of a line, counts them and emits finished lines.
module hlf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  hlf_in_if.sink               in_chan,
  input  logic                 q_full,
  output hlf_pkg::q_wr_t       q_wr
);

  hlf_pkg::line_t                chars_r;
  logic [hlf_pkg::CNT_W-1:0]     count_r;
  logic [hlf_pkg::CNT_W-1:0]     count_nxt;
  logic [hlf_pkg::CNT_W-1:0]     cnt_inc;
  logic                          acc;
  logic                          store;
  logic                          push;

  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && in_chan.ready;
  assign cnt_inc       = count_r + hlf_pkg::CNT_W'(1);

  always_comb begin
    count_nxt = count_r;
    store     = 1'b0;
    push      = 1'b0;
    if (acc && in_chan.ch != hlf_pkg::CH_SPACE) begin
      store = count_r < hlf_pkg::CNT_W'(hlf_pkg::KEPT_CHARS);
      if (cnt_inc >= hlf_pkg::CNT_W'(hlf_pkg::LINE_LIMIT - 1)) begin
        count_nxt = '0;
      end else if (in_chan.ch == hlf_pkg::CH_NEWLINE) begin
        count_nxt = '0;
        push      = cnt_inc > hlf_pkg::CNT_W'(hlf_pkg::KEPT_CHARS);
      end else begin
        count_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      chars_r[count_r[hlf_pkg::IDX_W-1:0]] <= in_chan.ch;
    end
  end

  // A line longer than the kept window never writes this cycle, so the
  // stored characters are complete when the line is pushed.
  assign q_wr.push      = push;
  assign q_wr.job.chars = chars_r;
  assign q_wr.job.full  = in_chan.queue_full;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < hlf_pkg::CNT_W'(hlf_pkg::LINE_LIMIT - 1))
    else $error("line count out of range");

endmodule

>>> rtl/hlf_queue.sv
// Two-entry queue of finished lines between front and back.
module hlf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hlf_pkg::q_wr_t       q_wr,
  output logic                 full,
  output logic                 rd_valid,
  output hlf_pkg::job_t        rd_job,
  input  logic                 rd_pop
);

  hlf_pkg::job_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(q_wr.push) - 2'(rd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue occupancy out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) q_wr.push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) rd_pop |-> rd_valid)
    else $error("pop from empty queue");

endmodule

>>> rtl/hlf_back.sv
// Back end: decodes a finished line into a CAN frame and holds it in the output register.
module hlf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  hlf_pkg::job_t        q_job,
  output logic                 q_pop,
  hlf_out_if.source            out_chan
);

  logic [7:0]       b [hlf_pkg::FRAME_BYTES];
  logic [15:0]      sum;
  hlf_pkg::result_t res_nxt;
  hlf_pkg::result_t res_r;
  logic             out_valid_r;

  always_comb begin
    for (int i = 0; i < hlf_pkg::FRAME_BYTES; i++) begin
      b[i] = {hlf_pkg::hex_nibble(q_job.chars[2*i]), hlf_pkg::hex_nibble(q_job.chars[2*i+1])};
    end
  end

  assign sum = ((16'(b[0]) + 16'(b[1])) + (16'(b[2]) + 16'(b[3])))
             + ((16'(b[4]) + 16'(b[5])) + (16'(b[6]) + 16'(b[7])))
             + (16'(b[8]) + 16'(b[9]));

  always_comb begin
    res_nxt = '0;
    if (q_job.full) begin
      res_nxt.dropped_full = 1'b1;
    end else begin
      res_nxt.push_message = 1'b1;
      res_nxt.checksum_bad = sum != {b[10], b[11]};
      res_nxt.reply_ok     = b[3] == 8'd0;
      res_nxt.can_id       = {b[0][3:0], b[1][6:0]};
      res_nxt.can_payload  = {b[2][3:0], b[3][3:0], b[4], b[5], b[6], b[7], b[8], b[9]};
      for (int i = 0; i < 8; i++) begin
        res_nxt.frame_head[63-8*i -: 8] = b[i];
      end
      for (int i = 0; i < 4; i++) begin
        res_nxt.frame_tail[31-8*i -: 8] = b[8+i];
      end
    end
  end

  // Load a new result when a line is waiting and the output register is empty or being drained.
  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.push_message = res_r.push_message;
  assign out_chan.dropped_full = res_r.dropped_full;
  assign out_chan.checksum_bad = res_r.checksum_bad;
  assign out_chan.reply_ok     = res_r.reply_ok;
  assign out_chan.can_id       = res_r.can_id;
  assign out_chan.can_payload  = res_r.can_payload;
  assign out_chan.frame_head   = res_r.frame_head;
  assign out_chan.frame_tail   = res_r.frame_tail;

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.push_message != res_r.dropped_full))
    else $error("result must be exactly one of push or drop");
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.dropped_full) |-> (res_r.frame_head == 64'd0 && !res_r.reply_ok))
    else $error("drop report carries frame data");

endmodule

>>> rtl/hex_line_frame_to_can_parser.sv
// Top level of the hex line frame parser: front, line queue and decode back end.
//
//   channel   | dir | payload                                     | transfer
//   ----------+-----+---------------------------------------------+-------------------
//   in_chan   | in  | ch[7:0], queue_full                         | valid && ready
//   out_chan  | out | push_message, dropped_full, checksum_bad,   | valid && ready
//             |     | reply_ok, can_id, can_payload, frame_head,  |
//             |     | frame_tail                                  |
//
// One character transaction per cycle is accepted while the line queue is not
// full. A newline that closes a long enough line is written into the line
// queue; the decode stage then loads the output register from the queue head
// once that register is empty or being drained, and out_chan.valid rises.
// Reset (rst_n low, synchronous) clears the line count, queue pointers and
// output valid; stored characters are not cleared.
// in_chan.ready drops only while the two-entry line queue is full, which
// happens only when out_chan is stalled.
module hex_line_frame_to_can_parser (
  input  logic        clk,
  input  logic        rst_n,
  hlf_in_if.sink      in_chan,
  hlf_out_if.source   out_chan
);

  hlf_pkg::q_wr_t q_wr;
  hlf_pkg::job_t  rd_job;
  logic           q_full;
  logic           rd_valid;
  logic           rd_pop;

  // Collect characters, track line length, hand off finished lines.
  hlf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  // Buffer finished lines so the front keeps going while the output stalls.
  hlf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_wr     (q_wr),
    .full     (q_full),
    .rd_valid (rd_valid),
    .rd_job   (rd_job),
    .rd_pop   (rd_pop)
  );

  // Decode hex, check the sum, build the CAN frame and hold it for the sink.
  hlf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (rd_valid),
    .q_job    (rd_job),
    .q_pop    (rd_pop),
    .out_chan (out_chan)
  );

endmodule
